// ----- src/pjqe_pkg.sv -----
// pjqe_pkg: shared types and codes for the penny jump quote engine
// holds the input and result item structs, order codes and register indexes
// no dependencies
package pjqe_pkg;

    // order kind codes
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_CANCEL = 1'b1;

    // order side codes
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // input item action codes
    localparam logic ACTION_BOOK    = 1'b0;
    localparam logic ACTION_CONFIRM = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRADER_ID      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE_SIZE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_INCREMENT = 2'd2;

    localparam int CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [15:0] TRADER_ID_RST      = 16'd0;
    localparam logic [15:0] QUOTE_SIZE_RST     = 16'd1;
    localparam logic [15:0] TICK_INCREMENT_RST = 16'd1;

    typedef struct packed {
        logic        action;
        logic [31:0] best_bid;
        logic [31:0] best_ask;
        logic [15:0] best_bid_size;
        logic [15:0] best_ask_size;
        logic [31:0] time_stamp;
        logic        take_bid;
        logic        confirm_side;
    } in_item_t;

    typedef struct packed {
        logic        order_kind;
        logic [15:0] order_trader;
        logic [31:0] order_number;
        logic [31:0] order_stamp;
        logic [15:0] order_qty;
        logic        order_side;
        logic [31:0] order_price;
        logic        last_of_run;
    } out_item_t;

endpackage

// ----- src/penny_jump_quote_engine.sv -----
// penny_jump_quote_engine: top level of the penny jump quote engine
// input register, quote decision logic and a two-entry order queue
// depends on pjqe_pkg
//
// usage
//   s_ channel: one transfer per item, a top-of-book update or a trade confirm
//   m_ channel: orders (cancel or add), last_of_run marks an item's final order
//   cfg_ channel: register writes, always ready, index 0 trader_id,
//     1 quote_size, 2 tick_increment, other indexes are dropped
// path: an s_ transfer passes through the input register, then the head of the
//   order queue, before the first order of its item is offered on m_
// throughput: one item per cycle while items give at most one order and m_ready
//   stays high; after an item that gives two orders, another item waits in the input
//   register until its first order leaves, as the single m_ port drains the queue
// stall: while m_ready is low the queue holds its orders and the input
//   register holds one more item, then s_ready drops
// reset: synchronous, active low; clears both resting quotes, the quote
//   counter, the queue and the input register, and loads register defaults
module penny_jump_quote_engine (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  pjqe_pkg::in_item_t                      s_data,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output pjqe_pkg::out_item_t                     m_data,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pjqe_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [pjqe_pkg::CFG_DATA_W-1:0]         cfg_data
);

    // configuration registers
    logic [15:0] trader_id_reg;
    logic [15:0] quote_size_reg;
    logic [15:0] tick_increment_reg;

    // input register
    logic                in_valid_reg;
    pjqe_pkg::in_item_t  in_data_reg;

    // resting quotes
    logic        bid_held_reg, bid_held_next;
    logic [31:0] bid_price_reg, bid_price_next;
    logic [15:0] bid_qty_reg, bid_qty_next;
    logic [31:0] bid_number_reg, bid_number_next;
    logic        ask_held_reg, ask_held_next;
    logic [31:0] ask_price_reg, ask_price_next;
    logic [15:0] ask_qty_reg, ask_qty_next;
    logic [31:0] ask_number_reg, ask_number_next;
    logic [31:0] quote_counter_reg, quote_counter_next;

    // order queue: head drives m_data, tail holds the second order
    logic [1:0]           cnt_reg, cnt_next;
    pjqe_pkg::out_item_t  head_reg, head_next;
    pjqe_pkg::out_item_t  tail_reg, tail_next;

    // decision results
    pjqe_pkg::out_item_t  res0, res1;
    logic [1:0]           res_cnt;
    logic                 pop;
    logic                 go;

    logic        spread_ok;
    logic        bid_stale, ask_stale;
    logic [31:0] counter_inc;
    logic [31:0] tick_ext;
    logic [31:0] spread;

    function automatic pjqe_pkg::out_item_t make_order(
        input logic        kind,
        input logic [15:0] trader,
        input logic [31:0] number,
        input logic [31:0] stamp,
        input logic [15:0] qty,
        input logic        side,
        input logic [31:0] price,
        input logic        last
    );
        pjqe_pkg::out_item_t o;
        o.order_kind   = kind;
        o.order_trader = trader;
        o.order_number = number;
        o.order_stamp  = stamp;
        o.order_qty    = qty;
        o.order_side   = side;
        o.order_price  = price;
        o.last_of_run  = last;
        return o;
    endfunction

    assign cfg_ready = 1'b1;
    assign m_valid   = (cnt_reg != 2'd0);
    assign m_data    = head_reg;
    assign pop       = m_valid && m_ready;

    // the item in the input register is decided once the queue will be empty
    assign go      = in_valid_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready));
    assign s_ready = !in_valid_reg || go;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trader_id_reg      <= pjqe_pkg::TRADER_ID_RST;
            quote_size_reg     <= pjqe_pkg::QUOTE_SIZE_RST;
            tick_increment_reg <= pjqe_pkg::TICK_INCREMENT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pjqe_pkg::CFG_TRADER_ID:      trader_id_reg      <= cfg_data;
                pjqe_pkg::CFG_QUOTE_SIZE:     quote_size_reg     <= cfg_data;
                pjqe_pkg::CFG_TICK_INCREMENT: tick_increment_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // spread test: ask must be strictly above bid and the gap above one tick
    assign tick_ext  = {16'd0, tick_increment_reg};
    assign spread    = in_data_reg.best_ask - in_data_reg.best_bid;
    assign spread_ok = (in_data_reg.best_ask > in_data_reg.best_bid) && (spread > tick_ext);

    assign bid_stale = bid_held_reg && ((bid_price_reg < in_data_reg.best_bid) ||
                                        (bid_qty_reg < in_data_reg.best_bid_size));
    assign ask_stale = ask_held_reg && ((ask_price_reg > in_data_reg.best_ask) ||
                                        (ask_qty_reg < in_data_reg.best_ask_size));
    assign counter_inc = quote_counter_reg + 32'd1;

    // quote decision
    always_comb begin
        pjqe_pkg::out_item_t bid_cxl, ask_cxl, bid_add, ask_add;

        bid_cxl = make_order(pjqe_pkg::KIND_CANCEL, trader_id_reg, bid_number_reg,
                             in_data_reg.time_stamp, bid_qty_reg, pjqe_pkg::SIDE_BUY,
                             bid_price_reg, 1'b0);
        ask_cxl = make_order(pjqe_pkg::KIND_CANCEL, trader_id_reg, ask_number_reg,
                             in_data_reg.time_stamp, ask_qty_reg, pjqe_pkg::SIDE_SELL,
                             ask_price_reg, 1'b0);
        bid_add = make_order(pjqe_pkg::KIND_ADD, trader_id_reg, counter_inc,
                             in_data_reg.time_stamp, quote_size_reg, pjqe_pkg::SIDE_BUY,
                             in_data_reg.best_bid + tick_ext, 1'b0);
        ask_add = make_order(pjqe_pkg::KIND_ADD, trader_id_reg, counter_inc,
                             in_data_reg.time_stamp, quote_size_reg, pjqe_pkg::SIDE_SELL,
                             in_data_reg.best_ask - tick_ext, 1'b0);

        bid_held_next      = bid_held_reg;
        bid_price_next     = bid_price_reg;
        bid_qty_next       = bid_qty_reg;
        bid_number_next    = bid_number_reg;
        ask_held_next      = ask_held_reg;
        ask_price_next     = ask_price_reg;
        ask_qty_next       = ask_qty_reg;
        ask_number_next    = ask_number_reg;
        quote_counter_next = quote_counter_reg;
        res0    = bid_cxl;
        res1    = ask_cxl;
        res_cnt = 2'd0;

        if (in_data_reg.action == pjqe_pkg::ACTION_CONFIRM) begin
            if (in_data_reg.confirm_side == pjqe_pkg::SIDE_BUY) begin
                bid_held_next = 1'b0;
            end else begin
                ask_held_next = 1'b0;
            end
        end else if (spread_ok) begin
            if (in_data_reg.take_bid) begin
                // cancel a stale bid, then quote one tick above the best bid
                if (!bid_held_reg || bid_stale) begin
                    bid_held_next      = 1'b1;
                    bid_price_next     = bid_add.order_price;
                    bid_qty_next       = quote_size_reg;
                    bid_number_next    = counter_inc;
                    quote_counter_next = counter_inc;
                    if (bid_stale) begin
                        res0    = bid_cxl;
                        res1    = bid_add;
                        res_cnt = 2'd2;
                    end else begin
                        res0    = bid_add;
                        res_cnt = 2'd1;
                    end
                end
            end else begin
                if (!ask_held_reg || ask_stale) begin
                    ask_held_next      = 1'b1;
                    ask_price_next     = ask_add.order_price;
                    ask_qty_next       = quote_size_reg;
                    ask_number_next    = counter_inc;
                    quote_counter_next = counter_inc;
                    if (ask_stale) begin
                        res0    = ask_cxl;
                        res1    = ask_add;
                        res_cnt = 2'd2;
                    end else begin
                        res0    = ask_add;
                        res_cnt = 2'd1;
                    end
                end
            end
        end else begin
            // narrow or crossed book: only cancels, bid first
            if (bid_stale) begin
                bid_held_next = 1'b0;
            end
            if (ask_stale) begin
                ask_held_next = 1'b0;
            end
            res0    = bid_stale ? bid_cxl : ask_cxl;
            res1    = ask_cxl;
            res_cnt = {1'b0, bid_stale} + {1'b0, ask_stale};
        end

        res0.last_of_run = (res_cnt == 2'd1);
        res1.last_of_run = 1'b1;
    end

    // order queue next state
    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (go) begin
            // queue is empty after this cycle's transfer
            cnt_next  = res_cnt;
            head_next = res0;
            tail_next = res1;
        end else if (pop) begin
            cnt_next  = cnt_reg - 2'd1;
            head_next = tail_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg           <= 2'd0;
            bid_held_reg      <= 1'b0;
            ask_held_reg      <= 1'b0;
            quote_counter_reg <= 32'd0;
        end else begin
            cnt_reg <= cnt_next;
            if (go) begin
                bid_held_reg      <= bid_held_next;
                ask_held_reg      <= ask_held_next;
                quote_counter_reg <= quote_counter_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
        if (go) begin
            bid_price_reg  <= bid_price_next;
            bid_qty_reg    <= bid_qty_next;
            bid_number_reg <= bid_number_next;
            ask_price_reg  <= ask_price_next;
            ask_qty_reg    <= ask_qty_next;
            ask_number_reg <= ask_number_next;
        end
    end

`ifndef NO_ASSERTIONS
    // queue never holds more than the two orders one item can cause
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("order queue count out of range");

    // a trade confirm leaves nothing to send
    a_confirm_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        go && (in_data_reg.action == pjqe_pkg::ACTION_CONFIRM) |=> !m_valid)
        else $error("trade confirm produced an order");

    // the last order in the queue always closes its run
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1) |-> head_reg.last_of_run)
        else $error("final queued order lacks last_of_run");

    // at most one new quote per decision
    a_counter_step: assert property (@(posedge aclk) disable iff (!aresetn)
        go |=> (quote_counter_reg == $past(quote_counter_reg)) ||
               (quote_counter_reg == $past(quote_counter_reg) + 32'd1))
        else $error("quote counter jumped");
`endif

endmodule
